// ----- rtl/ssaa_box_downsample_top_defines.svh -----
// assertion macros shared by the downsampler modules
`ifndef SSAA_BOX_DOWNSAMPLE_TOP_DEFINES_SVH
`define SSAA_BOX_DOWNSAMPLE_TOP_DEFINES_SVH
`ifndef SYNTH
`define SSAA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssaa assertion failed");
`define SSAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssaa assertion failed");
`else
`define SSAA_ASSERT(label, ante, cons)
`define SSAA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/ssaa_pkg.sv -----
package ssaa_pkg;

  localparam int CH_W       = 8;
  localparam int OW_W       = 11;
  localparam int OH_W       = 11;
  localparam int BLK_W      = 5;
  localparam int SW_W       = 15;
  localparam int COL_W      = 14;
  localparam int N_W        = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int SRC_WIDTH_MAX = 16384;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd4;

  typedef struct packed {
    logic            frame_start;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] avg_red;
    logic [CH_W-1:0] avg_green;
    logic [CH_W-1:0] avg_blue;
    logic            row_end;
    logic            frame_end;
  } result_t;

  // register values after range limiting
  typedef struct packed {
    logic [OW_W-1:0]  ow;
    logic [OH_W-1:0]  oh;
    logic [BLK_W-1:0] bw;
    logic [BLK_W-1:0] bh;
    logic [SW_W-1:0]  sw;
  } cfg_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic             first;
    logic             emit;
    logic [COL_W-1:0] blk;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [N_W-1:0]   n;
    logic             row_end;
    logic             frame_end;
  } op_t;

endpackage

// ----- rtl/ssaa_ram.sv -----
module ssaa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ssaa_opq.sv -----
module ssaa_opq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssaa_pkg::op_t  din,
  input  logic           pop,
  output ssaa_pkg::op_t  dout,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssaa_pkg::op_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign dout  = slots[rd_ptr];
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/ssaa_front.sv -----
`include "ssaa_box_downsample_top_defines.svh"

module ssaa_front (
  input  logic             clk,
  input  logic             rst,
  input  ssaa_pkg::cfg_t   cfg,
  input  logic             cfg_wr,
  input  logic             push,
  input  ssaa_pkg::pixel_t pixel,
  output logic             full,
  input  logic             q_full,
  output logic             op_push,
  output ssaa_pkg::op_t    op
);

  localparam int COL_W     = ssaa_pkg::COL_W;
  localparam int BLK_W     = ssaa_pkg::BLK_W;
  localparam int SW_W      = ssaa_pkg::SW_W;
  localparam int OH_W      = ssaa_pkg::OH_W;
  localparam int N_W       = ssaa_pkg::N_W;
  localparam int E2_W      = SW_W + 1;
  localparam int RI_W      = BLK_W + 1;
  localparam int DIV_STEPS = COL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DVS_W     = COL_W + BLK_W - 1;

  typedef enum logic [2:0] {
    F_RUN  = 3'b001,
    F_LOAD = 3'b010,
    F_DIV  = 3'b100
  } fstate_t;

  fstate_t           state;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  blk;
  logic [BLK_W-1:0]  sub;
  logic [COL_W-1:0]  base;
  logic [BLK_W-1:0]  rib;
  logic [OH_W-1:0]   orow;

  logic [COL_W-1:0]  dv_rem;
  logic [COL_W-1:0]  dv_q;
  logic [DVS_W-1:0]  dv_dvs;
  logic [CNT_W-1:0]  dv_cnt;

  logic [COL_W-1:0]  c_col;
  logic [COL_W-1:0]  c_blk;
  logic [BLK_W-1:0]  c_sub;
  logic [COL_W-1:0]  c_base;
  logic [BLK_W-1:0]  c_rib;
  logic [OH_W-1:0]   c_orow;

  logic              accept;
  logic              past;
  logic              col_ok;
  logic              fit_ok;
  logic              last_fit;
  logic              blk_ok;
  logic              rib_ok;
  logic              last_col;
  logic [COL_W-1:0]  ow_ext;
  logic [COL_W-1:0]  ow_m1_ext;
  logic [SW_W-1:0]   end1;
  logic [E2_W-1:0]   end2;
  logic [SW_W-1:0]   col_inc;
  logic [RI_W-1:0]   rib_inc;
  logic [RI_W-1:0]   sub_inc;
  logic              col_wrap;
  logic              rib_wrap;
  logic              sub_wrap;

  logic              dv_ge;
  logic              dv_last;
  logic [COL_W-1:0]  dv_rem_next;
  logic [COL_W-1:0]  dv_q_next;

  assign full   = (state != F_RUN) || q_full;
  assign accept = push && !full;

  // a frame start restarts all position counters for this item
  always_comb begin
    c_col  = pixel.frame_start ? '0 : col;
    c_blk  = pixel.frame_start ? '0 : blk;
    c_sub  = pixel.frame_start ? '0 : sub;
    c_base = pixel.frame_start ? '0 : base;
    c_rib  = pixel.frame_start ? '0 : rib;
    c_orow = pixel.frame_start ? '0 : orow;
  end

  always_comb begin
    ow_ext    = COL_W'(cfg.ow);
    ow_m1_ext = COL_W'(cfg.ow - 1'b1);
    end1      = {1'b0, c_base} + SW_W'(cfg.bw);
    end2      = {1'b0, end1} + E2_W'(cfg.bw);
    past      = (c_orow >= cfg.oh);
    col_ok    = ({1'b0, c_col} < cfg.sw);
    fit_ok    = (end1 <= cfg.sw);
    last_fit  = (end2 > {1'b0, cfg.sw});
    blk_ok    = (c_blk < ow_ext);
    rib_ok    = (c_rib < cfg.bh);
    last_col  = (c_blk == ow_m1_ext) || last_fit;

    col_inc  = {1'b0, c_col} + SW_W'(1);
    rib_inc  = {1'b0, c_rib} + RI_W'(1);
    sub_inc  = {1'b0, c_sub} + RI_W'(1);
    col_wrap = (col_inc >= cfg.sw);
    rib_wrap = (rib_inc >= {1'b0, cfg.bh});
    sub_wrap = (sub_inc >= {1'b0, cfg.bw});

    op_push = accept && !past && col_ok && fit_ok && blk_ok && rib_ok;

    op.first     = (c_rib == '0) && (c_sub == '0);
    op.emit      = (c_rib == cfg.bh - 1'b1) && (c_sub == cfg.bw - 1'b1);
    op.blk       = c_blk;
    op.red       = pixel.red;
    op.green     = pixel.green;
    op.blue      = pixel.blue;
    op.n         = N_W'(cfg.bw) * N_W'(cfg.bh);
    op.row_end   = last_col;
    op.frame_end = last_col && (c_orow == cfg.oh - 1'b1);
  end

  // column realignment after a register write: column / block width
  always_comb begin
    dv_ge       = (DVS_W'(dv_rem) >= dv_dvs);
    dv_rem_next = dv_ge ? (dv_rem - dv_dvs[COL_W-1:0]) : dv_rem;
    dv_q_next   = {dv_q[COL_W-2:0], dv_ge};
    dv_last     = (dv_cnt == CNT_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_RUN;
      col   <= '0;
      blk   <= '0;
      sub   <= '0;
      base  <= '0;
      rib   <= '0;
      orow  <= '0;
    end else begin
      if (accept && !past) begin
        if (col_wrap) begin
          col  <= '0;
          blk  <= '0;
          sub  <= '0;
          base <= '0;
          if (rib_wrap) begin
            rib  <= '0;
            orow <= c_orow + OH_W'(1);
          end else begin
            rib  <= rib_inc[BLK_W-1:0];
            orow <= c_orow;
          end
        end else begin
          col  <= col_inc[COL_W-1:0];
          rib  <= c_rib;
          orow <= c_orow;
          if (sub_wrap) begin
            sub  <= '0;
            blk  <= c_blk + COL_W'(1);
            base <= c_base + COL_W'(cfg.bw);
          end else begin
            sub  <= sub_inc[BLK_W-1:0];
            blk  <= c_blk;
            base <= c_base;
          end
        end
      end

      case (state)
        F_RUN: begin
          if (cfg_wr) begin
            state <= F_LOAD;
          end
        end
        F_LOAD: begin
          dv_rem <= col;
          dv_q   <= '0;
          dv_dvs <= {cfg.bw, {(COL_W-1){1'b0}}};
          dv_cnt <= '0;
          state  <= cfg_wr ? F_LOAD : F_DIV;
        end
        F_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          dv_dvs <= dv_dvs >> 1;
          dv_cnt <= dv_cnt + CNT_W'(1);
          if (cfg_wr) begin
            state <= F_LOAD;
          end else if (dv_last) begin
            blk   <= dv_q_next;
            sub   <= dv_rem_next[BLK_W-1:0];
            base  <= col - dv_rem_next;
            state <= F_RUN;
          end
        end
        default: begin
          state <= F_RUN;
        end
      endcase
    end
  end

  `SSAA_ASSERT(a_stall_realign, state != F_RUN, full)
  `SSAA_ASSERT(a_op_in_row, op_push, op.blk < ow_ext && !past)
  `SSAA_ASSERT_NEXT(a_realign_sub, state == F_DIV && dv_last && !cfg_wr, sub < cfg.bw)

endmodule

// ----- rtl/ssaa_back.sv -----
`include "ssaa_box_downsample_top_defines.svh"

module ssaa_back #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_BLOCK     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ssaa_pkg::op_t     op,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output ssaa_pkg::result_t result
);

  localparam int CH_W  = ssaa_pkg::CH_W;
  localparam int N_W   = ssaa_pkg::N_W;
  localparam int AW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int SUM_W = CH_W + 2 * $clog2(MAX_BLOCK);
  localparam int DV_W  = N_W + CH_W - 1;
  localparam int EXT_W = SUM_W + DV_W;
  localparam int QCW   = $clog2(CH_W);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ADD  = 4'b0010,
    B_DIV  = 4'b0100,
    B_PUT  = 4'b1000
  } bstate_t;

  bstate_t                    state;
  ssaa_pkg::op_t              op_r;
  logic [2:0][SUM_W-1:0]      rem;
  logic [2:0][CH_W-1:0]       quo;
  logic [DV_W-1:0]            dvs;
  logic [QCW-1:0]             cnt;
  logic                       out_valid;
  ssaa_pkg::result_t          res;

  logic                       ram_we;
  logic                       ram_re;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [3*SUM_W-1:0]         ram_wdata;
  logic [3*SUM_W-1:0]         ram_rdata;

  logic [2:0][SUM_W-1:0]      rd_lanes;
  logic [2:0][SUM_W-1:0]      head_lanes;
  logic [2:0][SUM_W-1:0]      add_lanes;
  logic [2:0][SUM_W-1:0]      rem_next;
  logic [2:0]                 ge;
  logic                       load_out;

  ssaa_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_lanes = ram_rdata;

  // lane 2 red, lane 1 green, lane 0 blue
  always_comb begin
    head_lanes[2] = SUM_W'(op.red);
    head_lanes[1] = SUM_W'(op.green);
    head_lanes[0] = SUM_W'(op.blue);
    add_lanes[2]  = rd_lanes[2] + SUM_W'(op_r.red);
    add_lanes[1]  = rd_lanes[1] + SUM_W'(op_r.green);
    add_lanes[0]  = rd_lanes[0] + SUM_W'(op_r.blue);
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    ram_re    = q_pop && !op.first;
    ram_raddr = op.blk[AW-1:0];
    ram_we    = (q_pop && op.first) || (state == B_ADD);
    ram_waddr = (state == B_ADD) ? op_r.blk[AW-1:0] : op.blk[AW-1:0];
    ram_wdata = (state == B_ADD) ? add_lanes : head_lanes;
    load_out  = (state == B_PUT) && (!out_valid || pop);
  end

  // restoring division, one quotient bit per cycle in each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ge[i]       = (EXT_W'(rem[i]) >= EXT_W'(dvs));
      rem_next[i] = ge[i] ? (rem[i] - SUM_W'(dvs)) : rem[i];
    end
  end

  assign empty  = !out_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            op_r <= op;
            if (op.first) begin
              if (op.emit) begin
                rem   <= head_lanes;
                dvs   <= {op.n, {(CH_W-1){1'b0}}};
                cnt   <= '0;
                state <= B_DIV;
              end
            end else begin
              state <= B_ADD;
            end
          end
        end
        B_ADD: begin
          if (op_r.emit) begin
            rem   <= add_lanes;
            dvs   <= {op_r.n, {(CH_W-1){1'b0}}};
            cnt   <= '0;
            state <= B_DIV;
          end else begin
            state <= B_IDLE;
          end
        end
        B_DIV: begin
          rem <= rem_next;
          for (int i = 0; i < 3; i++) begin
            quo[i] <= {quo[i][CH_W-2:0], ge[i]};
          end
          dvs <= dvs >> 1;
          cnt <= cnt + QCW'(1);
          if (cnt == QCW'(CH_W - 1)) begin
            state <= B_PUT;
          end
        end
        B_PUT: begin
          if (load_out) begin
            res.avg_red   <= quo[2];
            res.avg_green <= quo[1];
            res.avg_blue  <= quo[0];
            res.row_end   <= op_r.row_end;
            res.frame_end <= op_r.frame_end;
            state         <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  `SSAA_ASSERT(a_add_not_first, state == B_ADD, !op_r.first)
  `SSAA_ASSERT(a_frame_end_row_end, out_valid, !res.frame_end || res.row_end)
  `SSAA_ASSERT_NEXT(a_result_loaded, load_out, out_valid && state == B_IDLE)

endmodule

// ----- rtl/ssaa_box_downsample_top.sv -----
// Box-filter downsampler: source RGB pixels enter in raster order and each output item is
// the truncated per-channel mean of one block_w by block_h block, with row_end and frame_end
// marking the last block of a row and of the frame; columns and rows past the last whole block
// are dropped. The front end accepts one pixel per cycle, while not full, into a two-entry queue. The back end
// runs a read-modify-write on the column-sum RAM: a pixel that opens a block is written directly,
// any other pixel of a block takes a registered RAM read, then add and write, and the pixel
// that closes a block is followed by shift-subtract division and a load of the output register;
// the back end takes no new pixel from the queue until that result is loaded, and it waits for
// the output register to be free. After any register write the input stalls while the column
// position is split again into block and sub-column by a serial divider.
// The sum RAM needs no clearing; the first pixel of each block overwrites its entry.
module ssaa_box_downsample_top #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_BLOCK     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  ssaa_pkg::pixel_t                    pixel,
  output logic                                empty,
  input  logic                                pop,
  output ssaa_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssaa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OW_W  = ssaa_pkg::OW_W;
  localparam int OH_W  = ssaa_pkg::OH_W;
  localparam int BLK_W = ssaa_pkg::BLK_W;
  localparam int SW_W  = ssaa_pkg::SW_W;

  logic [OW_W-1:0]  out_width;
  logic [OH_W-1:0]  out_height;
  logic [BLK_W-1:0] block_w;
  logic [BLK_W-1:0] block_h;
  logic [SW_W-1:0]  src_width;

  logic             cfg_wr;
  ssaa_pkg::cfg_t   cfg;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  ssaa_pkg::op_t    q_din;
  ssaa_pkg::op_t    q_dout;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= OW_W'(1);
      out_height <= OH_W'(1);
      block_w    <= BLK_W'(1);
      block_h    <= BLK_W'(1);
      src_width  <= SW_W'(1);
    end else if (cfg_wr) begin
      case (cfg_index)
        ssaa_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[OW_W-1:0];
        ssaa_pkg::REG_OUT_HEIGHT: out_height <= cfg_data[OH_W-1:0];
        ssaa_pkg::REG_BLOCK_W:    block_w    <= cfg_data[BLK_W-1:0];
        ssaa_pkg::REG_BLOCK_H:    block_h    <= cfg_data[BLK_W-1:0];
        ssaa_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[SW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero counts as one; oversize output width, block and source width values saturate
  always_comb begin
    if (out_width == '0) begin
      cfg.ow = OW_W'(1);
    end else if (int'(out_width) > MAX_OUT_WIDTH) begin
      cfg.ow = OW_W'(MAX_OUT_WIDTH);
    end else begin
      cfg.ow = out_width;
    end

    cfg.oh = (out_height == '0) ? OH_W'(1) : out_height;

    if (block_w == '0) begin
      cfg.bw = BLK_W'(1);
    end else if (int'(block_w) > MAX_BLOCK) begin
      cfg.bw = BLK_W'(MAX_BLOCK);
    end else begin
      cfg.bw = block_w;
    end

    if (block_h == '0) begin
      cfg.bh = BLK_W'(1);
    end else if (int'(block_h) > MAX_BLOCK) begin
      cfg.bh = BLK_W'(MAX_BLOCK);
    end else begin
      cfg.bh = block_h;
    end

    if (src_width == '0) begin
      cfg.sw = SW_W'(1);
    end else if (int'(src_width) > ssaa_pkg::SRC_WIDTH_MAX) begin
      cfg.sw = SW_W'(ssaa_pkg::SRC_WIDTH_MAX);
    end else begin
      cfg.sw = src_width;
    end
  end

  ssaa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr),
    .push    (push),
    .pixel   (pixel),
    .full    (full),
    .q_full  (q_full),
    .op_push (q_push),
    .op      (q_din)
  );

  ssaa_opq u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ssaa_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_BLOCK     (MAX_BLOCK)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .op      (q_dout),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
